// File: hdl/nkdt_pkg.sv
// ----------------------------------------------------------------------------
// nkdt_pkg: shared types and constants for the name-keyed directory table
// Request modes, status codes, field widths, the probe token that walks the
// cell chain, the write command sent back to the cells, and name cleanup.
// ----------------------------------------------------------------------------
package nkdt_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int NAME_BYTES_DEF = 8;

    localparam int MODE_W   = 2;
    localparam int NAME_W   = 64;
    localparam int SECTOR_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int MAX_NAME_BYTES = NAME_W / 8;

    localparam logic [MODE_W-1:0] MODE_FIND     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_FILE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD_DIR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // Probe token: the request plus what the scan has found so far
    typedef struct packed {
        logic                vld;
        logic [MODE_W-1:0]   mode;
        logic [NAME_W-1:0]   name;
        logic [SECTOR_W-1:0] sector;
        logic                hit;
        logic [SECTOR_W-1:0] hit_sector;
        logic                hit_dir;
        logic                free;
    } nkdt_probe_t;

    // Write command broadcast to the cells after a scan
    typedef struct packed {
        logic                en;
        logic                set;
        logic                dir;
        logic [NAME_W-1:0]   name;
        logic [SECTOR_W-1:0] sector;
    } nkdt_wr_t;

    // Keep the low name bytes up to the first zero byte or nbytes, clear the rest
    function automatic logic [NAME_W-1:0] normalize_name(
        input logic [NAME_W-1:0] key,
        input int                nbytes
    );
        logic [NAME_W-1:0] out;
        logic              keep;
        out  = '0;
        keep = 1'b1;
        for (int b = 0; b < MAX_NAME_BYTES; b++) begin
            keep = keep && (b < nbytes) && (key[8*b +: 8] != 8'd0);
            if (keep) begin
                out[8*b +: 8] = key[8*b +: 8];
            end
        end
        return out;
    endfunction

endpackage

// File: hdl/nkdt_cell.sv
// ----------------------------------------------------------------------------
// nkdt_cell: one table entry in the scan chain
// Holds one entry, compares the passing probe against it, marks the first
// match and the first free slot, and takes broadcast writes to its index.
// ----------------------------------------------------------------------------
module nkdt_cell #(
    parameter int ENTRIES  = nkdt_pkg::ENTRIES_DEF,
    parameter int CELL_IDX = 0,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nkdt_pkg::nkdt_probe_t probe_i,
    input  logic [IDX_W-1:0]     hit_idx_i,
    input  logic [IDX_W-1:0]     free_idx_i,
    output nkdt_pkg::nkdt_probe_t probe_o,
    output logic [IDX_W-1:0]     hit_idx_o,
    output logic [IDX_W-1:0]     free_idx_o,
    input  nkdt_pkg::nkdt_wr_t   wr_i,
    input  logic [IDX_W-1:0]     wr_idx_i
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                            valid_reg;
    logic                            dir_reg;
    logic [nkdt_pkg::NAME_W-1:0]     name_reg;
    logic [nkdt_pkg::SECTOR_W-1:0]   sector_reg;

    nkdt_pkg::nkdt_probe_t probe_reg, probe_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    // Update the token with this entry's match and free status
    always_comb begin
        probe_next    = probe_i;
        hit_idx_next  = hit_idx_i;
        free_idx_next = free_idx_i;
        if (!probe_i.hit && valid_reg && (name_reg == probe_i.name)) begin
            probe_next.hit        = 1'b1;
            probe_next.hit_sector = sector_reg;
            probe_next.hit_dir    = dir_reg;
            hit_idx_next          = MY_IDX;
        end
        if (!probe_i.free && !valid_reg) begin
            probe_next.free = 1'b1;
            free_idx_next   = MY_IDX;
        end
    end

    // Advance the token to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg    <= '0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end else begin
            probe_reg    <= probe_next;
            hit_idx_reg  <= hit_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    // Apply a write addressed to this entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dir_reg   <= 1'b0;
        end else if (wr_i.en && (wr_idx_i == MY_IDX)) begin
            valid_reg <= wr_i.set;
            if (wr_i.set) begin
                dir_reg <= wr_i.dir;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_i.en && wr_i.set && (wr_idx_i == MY_IDX)) begin
            name_reg   <= wr_i.name;
            sector_reg <= wr_i.sector;
        end
    end

    assign probe_o    = probe_reg;
    assign hit_idx_o  = hit_idx_reg;
    assign free_idx_o = free_idx_reg;

endmodule

// File: hdl/nkdt_ctrl.sv
// ----------------------------------------------------------------------------
// nkdt_ctrl: request sequencer for the directory table
// Accepts a request, launches a probe down the cell chain, catches it at the
// far end, decides the status, issues the entry write and holds the result.
// ----------------------------------------------------------------------------
module nkdt_ctrl #(
    parameter int ENTRIES    = nkdt_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = nkdt_pkg::NAME_BYTES_DEF,
    localparam int IDX_W     = $clog2(ENTRIES)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nkdt_pkg::MODE_W-1:0]     s_mode,
    input  logic [nkdt_pkg::NAME_W-1:0]     s_name_key,
    input  logic [nkdt_pkg::SECTOR_W-1:0]   s_sector_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nkdt_pkg::STATUS_W-1:0]   m_status,
    output logic [nkdt_pkg::SLOT_W-1:0]     m_slot,
    output logic [nkdt_pkg::SECTOR_W-1:0]   m_sector_out,
    output logic                            m_is_dir,
    output nkdt_pkg::nkdt_probe_t           probe_o,
    output logic [IDX_W-1:0]                hit_idx_o,
    output logic [IDX_W-1:0]                free_idx_o,
    input  nkdt_pkg::nkdt_probe_t           probe_i,
    input  logic [IDX_W-1:0]                hit_idx_i,
    input  logic [IDX_W-1:0]                free_idx_i,
    output nkdt_pkg::nkdt_wr_t              wr_o,
    output logic [IDX_W-1:0]                wr_idx_o
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    nkdt_pkg::nkdt_probe_t launch_reg;
    nkdt_pkg::nkdt_probe_t fin_reg;
    logic [IDX_W-1:0]      fin_hit_idx_reg;
    logic [IDX_W-1:0]      fin_free_idx_reg;

    logic                            m_valid_reg;
    logic [nkdt_pkg::STATUS_W-1:0]   status_reg;
    logic [nkdt_pkg::SLOT_W-1:0]     slot_reg;
    logic [nkdt_pkg::SECTOR_W-1:0]   sector_out_reg;
    logic                            is_dir_reg;

    logic                            s_fire;
    logic                            commit;
    logic [nkdt_pkg::STATUS_W-1:0]   status_c;
    logic [nkdt_pkg::SLOT_W-1:0]     slot_c;
    logic [nkdt_pkg::SECTOR_W-1:0]   sector_c;
    logic                            dir_c;
    nkdt_pkg::nkdt_wr_t              wr_c;
    logic [IDX_W-1:0]                wr_idx_c;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign commit  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Sequence one request at a time
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (probe_i.vld) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Launch a clean probe on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg <= '0;
        end else begin
            launch_reg.vld        <= s_fire;
            launch_reg.mode       <= s_mode;
            launch_reg.name       <= nkdt_pkg::normalize_name(s_name_key, NAME_BYTES);
            launch_reg.sector     <= s_sector_in;
            launch_reg.hit        <= 1'b0;
            launch_reg.hit_sector <= '0;
            launch_reg.hit_dir    <= 1'b0;
            launch_reg.free       <= 1'b0;
        end
    end

    assign probe_o    = launch_reg;
    assign hit_idx_o  = '0;
    assign free_idx_o = '0;

    // Catch the probe at the end of the chain
    always_ff @(posedge aclk) begin
        if ((state_reg == S_SCAN) && probe_i.vld) begin
            fin_reg          <= probe_i;
            fin_hit_idx_reg  <= hit_idx_i;
            fin_free_idx_reg <= free_idx_i;
        end
    end

    // Decide the status and the entry write
    always_comb begin
        status_c    = nkdt_pkg::STAT_OK;
        slot_c      = '0;
        sector_c    = '0;
        dir_c       = 1'b0;
        wr_c.en     = 1'b0;
        wr_c.set    = 1'b0;
        wr_c.dir    = (fin_reg.mode == nkdt_pkg::MODE_ADD_DIR);
        wr_c.name   = fin_reg.name;
        wr_c.sector = fin_reg.sector;
        wr_idx_c    = fin_hit_idx_reg;
        unique case (fin_reg.mode)
            nkdt_pkg::MODE_FIND: begin
                if (fin_reg.hit) begin
                    slot_c   = nkdt_pkg::SLOT_W'(fin_hit_idx_reg);
                    sector_c = fin_reg.hit_sector;
                    dir_c    = fin_reg.hit_dir;
                end else begin
                    status_c = nkdt_pkg::STAT_NOT_FOUND;
                end
            end
            nkdt_pkg::MODE_REMOVE: begin
                if (fin_reg.hit) begin
                    slot_c  = nkdt_pkg::SLOT_W'(fin_hit_idx_reg);
                    wr_c.en = commit;
                end else begin
                    status_c = nkdt_pkg::STAT_NOT_FOUND;
                end
            end
            nkdt_pkg::MODE_ADD_FILE, nkdt_pkg::MODE_ADD_DIR: begin
                if (fin_reg.hit) begin
                    status_c = nkdt_pkg::STAT_DUPLICATE;
                end else if (!fin_reg.free) begin
                    status_c = nkdt_pkg::STAT_FULL;
                end else begin
                    slot_c   = nkdt_pkg::SLOT_W'(fin_free_idx_reg);
                    wr_c.en  = commit;
                    wr_c.set = 1'b1;
                    wr_idx_c = fin_free_idx_reg;
                end
            end
            default: begin
                status_c = nkdt_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    assign wr_o     = wr_c;
    assign wr_idx_o = wr_idx_c;

    // Hold the result until the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            status_reg     <= status_c;
            slot_reg       <= slot_c;
            sector_out_reg <= sector_c;
            is_dir_reg     <= dir_c;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_slot       = slot_reg;
    assign m_sector_out = sector_out_reg;
    assign m_is_dir     = is_dir_reg;

endmodule

// File: hdl/name_keyed_directory_table_top.sv
// ----------------------------------------------------------------------------
// A request passes a launch register, walks the entry chain one cell per cycle,
// is caught in a catch register at the far end and then commits its result
// and its entry write. A new request is accepted only once the last one has
// committed; a result still waiting holds back that commit and the next request.
// Reset clears every entry's valid and directory flags at once; no sweep.
// ----------------------------------------------------------------------------
// name_keyed_directory_table_top: fixed directory table with name lookup
// Find, add file, add directory and remove requests over a chain of entry
// cells, each returning one status transaction.
// ----------------------------------------------------------------------------
module name_keyed_directory_table_top #(
    parameter int ENTRIES    = nkdt_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = nkdt_pkg::NAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nkdt_pkg::MODE_W-1:0]     s_mode,
    input  logic [nkdt_pkg::NAME_W-1:0]     s_name_key,
    input  logic [nkdt_pkg::SECTOR_W-1:0]   s_sector_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nkdt_pkg::STATUS_W-1:0]   m_status,
    output logic [nkdt_pkg::SLOT_W-1:0]     m_slot,
    output logic [nkdt_pkg::SECTOR_W-1:0]   m_sector_out,
    output logic                            m_is_dir
);

    localparam int IDX_W = $clog2(ENTRIES);

    nkdt_pkg::nkdt_probe_t probe_chain [0:ENTRIES];
    logic [IDX_W-1:0]      hit_chain   [0:ENTRIES];
    logic [IDX_W-1:0]      free_chain  [0:ENTRIES];
    nkdt_pkg::nkdt_wr_t    wr;
    logic [IDX_W-1:0]      wr_idx;

    // Sequence requests and decide results
    nkdt_ctrl #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_name_key   (s_name_key),
        .s_sector_in  (s_sector_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot       (m_slot),
        .m_sector_out (m_sector_out),
        .m_is_dir     (m_is_dir),
        .probe_o      (probe_chain[0]),
        .hit_idx_o    (hit_chain[0]),
        .free_idx_o   (free_chain[0]),
        .probe_i      (probe_chain[ENTRIES]),
        .hit_idx_i    (hit_chain[ENTRIES]),
        .free_idx_i   (free_chain[ENTRIES]),
        .wr_o         (wr),
        .wr_idx_o     (wr_idx)
    );

    // Chain of entry cells, lowest index first
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        nkdt_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .probe_i    (probe_chain[i]),
            .hit_idx_i  (hit_chain[i]),
            .free_idx_i (free_chain[i]),
            .probe_o    (probe_chain[i+1]),
            .hit_idx_o  (hit_chain[i+1]),
            .free_idx_o (free_chain[i+1]),
            .wr_i       (wr),
            .wr_idx_i   (wr_idx)
        );
    end

endmodule
